/* rtl/core/wss_pkg.sv */
// Shared types, codes and constants for the wind sample scheduler and logger.
`default_nettype none

package wss_pkg;

    // Log ring geometry
    localparam int LOG_DEPTH    = 100;
    localparam int LOG_INTERVAL = 10;
    localparam int LOG_AW       = $clog2(LOG_DEPTH);

    // Result queue depth (pointers are one bit wide)
    localparam int OUTQ_DEPTH   = 2;

    // Fixed field widths
    localparam int SPEED_W  = 16;
    localparam int DIR_W    = 9;
    localparam int COUNT_W  = 7;
    localparam int AGE_W    = 7;
    localparam int ADC_W    = 12;
    localparam int PULSE_W  = 8;
    localparam int PERIOD_W = 8;
    localparam int LOGCNT_W = 4;
    localparam int RSPEED_W = 8;
    localparam int REC_W    = RSPEED_W + DIR_W;

    // floor(adc*116/1000) == (adc * DIR_MULT) >> DIR_SHIFT for every 12-bit adc
    localparam int DIR_MULT_W = 22;
    localparam int DIR_PROD_W = ADC_W + DIR_MULT_W;
    localparam logic [DIR_MULT_W-1:0] DIR_MULT = 22'd3892322;
    localparam int DIR_SHIFT = 25;
    localparam logic [DIR_W-1:0] DIR_WRAP = 9'd360;

    // Configuration register reset value
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 8'd2;

    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_READ    = 2'd1,
        OP_RESTART = 2'd2,
        OP_CLEAR   = 2'd3
    } t_op;

    typedef enum logic {
        CFG_SPEED_PERIOD = 1'b0,
        CFG_DIR_PERIOD   = 1'b1
    } t_cfg_idx;

    // Log store access issued with an accepted item
    typedef struct packed {
        logic              we;
        logic [LOG_AW-1:0] waddr;
        logic [REC_W-1:0]  wdata;
        logic              re;
        logic [LOG_AW-1:0] raddr;
    } t_ram_req;

    // Result fields known at accept time (record data follows from the store)
    typedef struct packed {
        logic [SPEED_W-1:0] speed;
        logic [DIR_W-1:0]   dir;
        logic               logged;
        logic [COUNT_W-1:0] count;
        logic               rvalid;
    } t_early;

    // Complete result item
    typedef struct packed {
        logic [SPEED_W-1:0]  speed;
        logic [DIR_W-1:0]    dir;
        logic                logged;
        logic [COUNT_W-1:0]  count;
        logic [RSPEED_W-1:0] rspeed;
        logic [DIR_W-1:0]    rdir;
        logic                rvalid;
    } t_result;

endpackage

`default_nettype wire

/* rtl/core/wss_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module wss_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 100
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* rtl/core/wss_ctrl.sv */
// Tick scheduler state, configuration registers and log ring bookkeeping.
`default_nettype none

module wss_ctrl (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_accept,
    input  wire wss_pkg::t_op                     i_op,
    input  wire logic [wss_pkg::PULSE_W-1:0]      i_pulses,
    input  wire logic [wss_pkg::ADC_W-1:0]        i_adc,
    input  wire logic [wss_pkg::AGE_W-1:0]        i_age,
    input  wire logic                             i_cfg_we,
    input  wire wss_pkg::t_cfg_idx                i_cfg_index,
    input  wire logic [wss_pkg::PERIOD_W-1:0]     i_cfg_data,
    output wss_pkg::t_ram_req                     o_ram,
    output wss_pkg::t_early                       o_early
);

    import wss_pkg::*;

    logic [PERIOD_W-1:0] r_speed_period, r_dir_period;
    logic [PERIOD_W-1:0] r_sc, n_sc, r_dc, n_dc;
    logic [LOGCNT_W-1:0] r_lc, n_lc;
    logic [SPEED_W-1:0]  r_acc, n_acc, r_pend, n_pend, r_shown_speed, n_shown_speed;
    logic [DIR_W-1:0]    r_shown_dir, n_shown_dir;
    logic [LOG_AW-1:0]   r_wp, n_wp;
    logic [COUNT_W-1:0]  r_cnt, n_cnt;

    logic [SPEED_W:0]    acc_sum;
    logic [SPEED_W-1:0]  acc_sat;
    logic [PERIOD_W-1:0] sc_inc, dc_inc;
    logic [LOGCNT_W-1:0] lc_inc;
    logic [DIR_PROD_W-1:0] dir_prod;
    logic [DIR_W-1:0]    dir_q, dir_new;
    logic [SPEED_W+2:0]  acc_x7;
    logic [LOG_AW-1:0]   wp_inc;
    logic [AGE_W:0]      age_diff, age_idx;
    logic                age_ok;
    logic                log_fire;
    logic                logged;
    t_ram_req            ram;

    // Datapath pieces shared by the operations
    always_comb begin
        acc_sum  = {1'b0, r_acc} + (SPEED_W+1)'(i_pulses);
        acc_sat  = acc_sum[SPEED_W] ? {SPEED_W{1'b1}} : acc_sum[SPEED_W-1:0];
        sc_inc   = r_sc + 1'b1;
        dc_inc   = r_dc + 1'b1;
        lc_inc   = r_lc + 1'b1;
        dir_prod = DIR_PROD_W'(i_adc) * DIR_PROD_W'(DIR_MULT);
        dir_q    = DIR_W'(dir_prod >> DIR_SHIFT);
        dir_new  = (dir_q >= DIR_WRAP) ? (dir_q - DIR_WRAP) : dir_q;
        wp_inc   = (r_wp == LOG_AW'(LOG_DEPTH - 1)) ? '0 : r_wp + 1'b1;
        // newest record sits just below the write position
        age_diff = (AGE_W+1)'(r_wp) - (AGE_W+1)'(1) - (AGE_W+1)'(i_age);
        age_idx  = age_diff[AGE_W] ? age_diff + (AGE_W+1)'(LOG_DEPTH) : age_diff;
        age_ok   = (i_age < r_cnt);
    end

    // Next state per operation
    always_comb begin
        n_sc          = r_sc;
        n_dc          = r_dc;
        n_lc          = r_lc;
        n_acc         = r_acc;
        n_pend        = r_pend;
        n_shown_speed = r_shown_speed;
        n_shown_dir   = r_shown_dir;
        n_wp          = r_wp;
        n_cnt         = r_cnt;
        log_fire      = 1'b0;
        acc_x7        = '0;
        unique case (i_op)
            OP_TICK: begin
                n_acc = acc_sat;
                n_sc  = sc_inc;
                n_dc  = dc_inc;
                n_lc  = lc_inc;
                if (sc_inc >= r_speed_period) begin
                    n_shown_speed = r_pend;
                    n_sc          = '0;
                end
                if (dc_inc >= r_dir_period) begin
                    n_shown_dir = dir_new;
                    n_dc        = '0;
                end
                if (lc_inc >= LOGCNT_W'(LOG_INTERVAL)) begin
                    log_fire = 1'b1;
                    n_wp     = wp_inc;
                    n_cnt    = (r_cnt < COUNT_W'(LOG_DEPTH)) ? r_cnt + 1'b1 : r_cnt;
                    n_lc     = '0;
                end
                // odd log count: refresh pending speed from the pulse total
                if (n_lc[0]) begin
                    acc_x7 = ((SPEED_W+3)'(acc_sat) << 3) - (SPEED_W+3)'(acc_sat);
                    n_pend = (acc_sat == '0) ? '0 : acc_x7[SPEED_W+2:3] + 1'b1;
                    n_acc  = '0;
                end
            end
            OP_READ: begin
            end
            OP_RESTART: begin
                n_sc  = '0;
                n_dc  = '0;
                n_lc  = '0;
                n_acc = '0;
            end
            OP_CLEAR: begin
                n_wp  = '0;
                n_cnt = '0;
            end
            default: begin
            end
        endcase
    end

    // Store request and early result fields
    always_comb begin
        logged    = (i_op == OP_TICK) && log_fire;
        ram.we    = i_accept && logged;
        ram.waddr = r_wp;
        ram.wdata = {n_shown_speed[RSPEED_W-1:0], n_shown_dir};
        ram.re    = i_accept && (i_op == OP_READ);
        ram.raddr = LOG_AW'(age_idx);

        o_early.speed  = n_shown_speed;
        o_early.dir    = n_shown_dir;
        o_early.logged = logged;
        o_early.count  = n_cnt;
        o_early.rvalid = (i_op == OP_READ) && age_ok;
    end

    assign o_ram = ram;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_period <= PERIOD_RESET;
            r_dir_period   <= PERIOD_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SPEED_PERIOD: r_speed_period <= i_cfg_data;
                CFG_DIR_PERIOD:   r_dir_period   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Scheduler state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sc          <= '0;
            r_dc          <= '0;
            r_lc          <= '0;
            r_acc         <= '0;
            r_pend        <= '0;
            r_shown_speed <= '0;
            r_shown_dir   <= '0;
            r_wp          <= '0;
            r_cnt         <= '0;
        end else if (i_accept) begin
            r_sc          <= n_sc;
            r_dc          <= n_dc;
            r_lc          <= n_lc;
            r_acc         <= n_acc;
            r_pend        <= n_pend;
            r_shown_speed <= n_shown_speed;
            r_shown_dir   <= n_shown_dir;
            r_wp          <= n_wp;
            r_cnt         <= n_cnt;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/wss_outq.sv */
// Result stage: holds an item while its record is read, then a two-entry output queue.
`default_nettype none

module wss_outq (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_accept,
    input  wire wss_pkg::t_early             i_early,
    input  wire logic [wss_pkg::REC_W-1:0]   i_rd_data,
    input  wire logic                        i_out_stall,
    output logic                             o_ready,
    output logic                             o_out_valid,
    output wss_pkg::t_result                 o_result
);

    import wss_pkg::*;

    t_early            r_p;
    logic              r_p_valid;
    t_result           r_q [OUTQ_DEPTH];
    logic              r_wr_ptr, r_rd_ptr;
    logic [1:0]        r_qcnt, n_qcnt;
    t_result           p_res;
    logic              p_move, pop;

    // Merge the record read from the store into the held item
    always_comb begin
        p_res.speed  = r_p.speed;
        p_res.dir    = r_p.dir;
        p_res.logged = r_p.logged;
        p_res.count  = r_p.count;
        p_res.rvalid = r_p.rvalid;
        p_res.rspeed = r_p.rvalid ? i_rd_data[REC_W-1:DIR_W] : '0;
        p_res.rdir   = r_p.rvalid ? i_rd_data[DIR_W-1:0] : '0;
    end

    // Handshake: the held item moves on whenever the queue has room
    always_comb begin
        p_move      = r_p_valid && (r_qcnt != 2'(OUTQ_DEPTH));
        o_ready     = !r_p_valid || p_move;
        o_out_valid = (r_qcnt != '0);
        pop         = o_out_valid && !i_out_stall;
        n_qcnt      = r_qcnt + 2'(p_move) - 2'(pop);
        o_result    = r_q[r_rd_ptr];
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_wr_ptr  <= 1'b0;
            r_rd_ptr  <= 1'b0;
            r_qcnt    <= '0;
        end else begin
            if (o_ready) begin
                r_p_valid <= i_accept;
            end
            if (p_move) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_qcnt <= n_qcnt;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_p <= i_early;
        end
        if (p_move) begin
            r_q[r_wr_ptr] <= p_res;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/wind_sample_scheduler_logger.sv */
// Wind sample scheduler and logger: tick scheduling, speed/direction sampling, record ring.
// Throughput: one item per cycle, except while a held item waits for a full queue;
// the log store has one write and one registered read port.
// Up to three items may be in flight (one stage waiting on the store read, two queued).
// Reset (synchronous, active low) clears counters, shown values and the ring count;
// periods return to 2. Store contents are not cleared.
`default_nettype none

module wind_sample_scheduler_logger (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [1:0]                    i_operation,
    input  wire logic [wss_pkg::PULSE_W-1:0]   i_pulses,
    input  wire logic [wss_pkg::ADC_W-1:0]     i_adc_sample,
    input  wire logic [wss_pkg::AGE_W-1:0]     i_record_age,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [wss_pkg::SPEED_W-1:0]        o_speed_tenths,
    output logic [wss_pkg::DIR_W-1:0]          o_direction_deg,
    output logic                               o_logged,
    output logic [wss_pkg::COUNT_W-1:0]        o_record_count,
    output logic [wss_pkg::RSPEED_W-1:0]       o_record_speed,
    output logic [wss_pkg::DIR_W-1:0]          o_record_direction,
    output logic                               o_record_valid,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic                          i_cfg_index,
    input  wire logic [wss_pkg::PERIOD_W-1:0]  i_cfg_data
);

    import wss_pkg::*;

    logic              ready;
    logic              accept;
    t_ram_req          ram;
    t_early            early;
    t_result           result;
    logic [REC_W-1:0]  rd_data;

    assign o_in_stall  = !ready;
    assign accept      = i_in_valid && ready;
    assign o_cfg_ready = 1'b1;

    wss_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_op        (t_op'(i_operation)),
        .i_pulses    (i_pulses),
        .i_adc       (i_adc_sample),
        .i_age       (i_record_age),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (t_cfg_idx'(i_cfg_index)),
        .i_cfg_data  (i_cfg_data),
        .o_ram       (ram),
        .o_early     (early)
    );

    wss_ram #(
        .WIDTH (REC_W),
        .DEPTH (LOG_DEPTH)
    ) u_log_ram (
        .i_clk   (i_clk),
        .i_we    (ram.we),
        .i_waddr (ram.waddr),
        .i_wdata (ram.wdata),
        .i_re    (ram.re),
        .i_raddr (ram.raddr),
        .o_rdata (rd_data)
    );

    wss_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_early     (early),
        .i_rd_data   (rd_data),
        .i_out_stall (i_out_stall),
        .o_ready     (ready),
        .o_out_valid (o_out_valid),
        .o_result    (result)
    );

    assign o_speed_tenths     = result.speed;
    assign o_direction_deg    = result.dir;
    assign o_logged           = result.logged;
    assign o_record_count     = result.count;
    assign o_record_speed     = result.rspeed;
    assign o_record_direction = result.rdir;
    assign o_record_valid     = result.rvalid;

`ifndef NO_ASSERTIONS
    // Ring count never passes the ring depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_record_count <= COUNT_W'(LOG_DEPTH)))
        else $error("record count above ring depth");

    // Direction always reduced modulo a full turn
    a_dir_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_direction_deg < DIR_WRAP))
        else $error("direction out of range");

    // A valid record read needs a non-empty ring and is never a logging tick
    a_read_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_record_valid) |-> (o_record_count != '0 && !o_logged))
        else $error("record read inconsistent with ring state");

    // An item accepted into an empty output appears as a result when nothing stalls
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !o_out_valid) ##1 !i_out_stall |=> o_out_valid)
        else $error("accepted item did not reach the output");
`endif

endmodule

`default_nettype wire
